/* src/text_console_char_engine_core_macros.svh */
// Assertion macros for the text console character engine.
// Used by the checker only; no other dependencies.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_NOW(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/tcce_pkg.sv */
// Shared constants for the text console character engine.
// No dependencies.
package tcce_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int CURSOR_W   = 11;
   localparam int INDEX_W    = 11;
   localparam int TAB_STEP   = 8;

   localparam logic [1:0] FUNC_PUT     = 2'd0;
   localparam logic [1:0] FUNC_RECOLOR = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   localparam logic [7:0] BLANK_ATTR_RESET = 8'h0F;

endpackage

/* src/text_console_char_engine_core.sv */
// Text console engine: put/recolor/read on a ROWS x COLUMNS screen of 16-bit cells.
// After reset a clearing pass writes every cell, with req_ready low.
// Put: result goes via ST_DONE to the response registers; a scrolling put first walks
// ST_SCROLL and ST_FILL. Recolor: ST_RECOLOR, read: ST_READ, each then ST_DONE.
// One item at a time, set by the screen memory walked one cell per cycle with one
// read and one write port. Reset is synchronous.
module text_console_char_engine_core
   import tcce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [7:0]          req_char_code,
   input  logic [7:0]          req_attribute,
   input  logic [INDEX_W-1:0]  req_cell_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CURSOR_W-1:0] rsp_cursor_position,
   output logic [15:0]         rsp_read_data,
   output logic                rsp_scrolled,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCROLL, ST_FILL, ST_RECOLOR, ST_READ, ST_DONE
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] ROW1_ADDR = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] BOT_ADDR  = ADDR_W'(CELL_COUNT - COLUMNS);

   logic [15:0] screen_ff [CELL_COUNT];
   logic [15:0] mem_rdata_ff;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic                pend_recolor_ff, pend_recolor_in;
   logic [ADDR_W-1:0]   waddr_ff, waddr_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [7:0]          attr_ff, attr_in;
   logic [7:0]          blank_ff;
   logic                in_range_ff, in_range_in;
   logic [15:0]         res_data_ff, res_data_in;
   logic                res_scrolled_ff, res_scrolled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_scrolled_ff, rsp_scrolled_in;

   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [15:0]         mem_wdata;

   logic [ADDR_W-1:0]   pos;
   logic [COL_W:0]      ncol;
   logic [ROW_W:0]      nrow;
   logic                is_print;
   logic                accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign pos       = ADDR_W'(row_ff * COLUMNS + col_ff);
   assign is_print  = req_char_code inside {[CH_SPACE:CH_TILDE]};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_read_data       = rsp_data_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;

   always_comb begin
      ncol = {1'b0, col_ff};
      nrow = {1'b0, row_ff};
      case (req_char_code)
         CH_BS: begin
            if (col_ff != '0) ncol = {1'b0, col_ff} - 1'b1;
         end
         CH_TAB: begin
            ncol = ({1'b0, col_ff} + (COL_W + 1)'(TAB_STEP)) & ~((COL_W + 1)'(TAB_STEP - 1));
         end
         CH_CR: ncol = '0;
         CH_LF: begin
            ncol = '0;
            nrow = {1'b0, row_ff} + 1'b1;
         end
         default: begin
            if (is_print) ncol = {1'b0, col_ff} + 1'b1;
         end
      endcase
      if (ncol >= COLUMNS) begin
         ncol = '0;
         nrow = nrow + 1'b1;
      end
   end

   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      pend_in         = 1'b0;
      pend_recolor_in = pend_recolor_ff;
      waddr_in        = waddr_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      attr_in         = attr_ff;
      in_range_in     = in_range_ff;
      res_data_in     = res_data_ff;
      res_scrolled_in = res_scrolled_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_pos_in      = rsp_pos_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_we          = 1'b0;
      mem_waddr       = ptr_ff;
      mem_wdata       = {blank_ff, CH_SPACE};
      mem_re          = 1'b0;
      mem_raddr       = ptr_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = {BLANK_ATTR_RESET, CH_SPACE};
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               res_data_in     = '0;
               res_scrolled_in = 1'b0;
               attr_in         = req_attribute;
               case (req_func)
                  FUNC_PUT: begin
                     if (is_print) begin
                        mem_we    = 1'b1;
                        mem_waddr = pos;
                        mem_wdata = {req_attribute, req_char_code};
                     end
                     col_in = COL_W'(ncol);
                     if (nrow == (ROW_W + 1)'(ROWS)) begin
                        row_in          = ROW_W'(ROWS - 1);
                        res_scrolled_in = 1'b1;
                        ptr_in          = ROW1_ADDR;
                        state_in        = ST_SCROLL;
                     end else begin
                        row_in   = ROW_W'(nrow);
                        state_in = ST_DONE;
                     end
                  end
                  FUNC_RECOLOR: begin
                     ptr_in   = '0;
                     state_in = ST_RECOLOR;
                  end
                  FUNC_READ: begin
                     mem_re      = 1'b1;
                     mem_raddr   = ADDR_W'(req_cell_index);
                     in_range_in = (req_cell_index < CELL_COUNT);
                     state_in    = ST_READ;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SCROLL: begin
            mem_re          = 1'b1;
            pend_in         = 1'b1;
            pend_recolor_in = 1'b0;
            waddr_in        = ptr_ff - ROW1_ADDR;
            ptr_in          = ptr_ff + 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = BOT_ADDR;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (!pend_ff) begin
               mem_we = 1'b1;
               ptr_in = ptr_ff + 1'b1;
               if (ptr_ff == LAST_ADDR) state_in = ST_DONE;
            end
         end
         ST_RECOLOR: begin
            mem_re          = 1'b1;
            pend_in         = 1'b1;
            pend_recolor_in = 1'b1;
            waddr_in        = ptr_ff;
            ptr_in          = ptr_ff + 1'b1;
            if (ptr_ff == LAST_ADDR) state_in = ST_DONE;
         end
         ST_READ: begin
            res_data_in = in_range_ff ? mem_rdata_ff : 16'h0000;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_pos_in      = CURSOR_W'(pos);
               rsp_data_in     = res_data_ff;
               rsp_scrolled_in = res_scrolled_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = waddr_ff;
         mem_wdata = pend_recolor_ff ? {attr_ff, mem_rdata_ff[7:0]} : mem_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) screen_ff[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= screen_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         blank_ff     <= BLANK_ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) blank_ff <= csr_write_data;
      end
      pend_recolor_ff <= pend_recolor_in;
      waddr_ff        <= waddr_in;
      attr_ff         <= attr_in;
      in_range_ff     <= in_range_in;
      res_data_ff     <= res_data_in;
      res_scrolled_ff <= res_scrolled_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

endmodule

/* src/tcce_checker.sv */
// Port-level checks for text_console_char_engine_core, bound into the core module.
// Depends on tcce_pkg and text_console_char_engine_core_macros.svh.
`include "text_console_char_engine_core_macros.svh"

module tcce_checker
   import tcce_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [CURSOR_W-1:0] rsp_cursor_position
);

   `TCCE_ASSERT_NEXT(a_busy_after_reset, clock, 1'b0, reset, !req_ready)
   `TCCE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `TCCE_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TCCE_ASSERT_NOW(a_cursor_on_screen, clock, reset, rsp_valid,
      (CELL_COUNT > (1 << CURSOR_W)) || (rsp_cursor_position < CELL_COUNT))

endmodule

bind text_console_char_engine_core tcce_checker u_tcce_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_cursor_position (rsp_cursor_position)
);

/* dv/tb.sv */
// Self-checking testbench for text_console_char_engine_core: directed table, then random items.
// Holds its own screen, cursor and blank attribute copy; depends on tcce_pkg and the core only.
module tb;
   import tcce_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int PHASE_ITEMS      = 53;
   localparam int SETTLE_CYCLES    = 4;
   localparam int TAIL_CYCLES      = 16;
   localparam int HOLD_OFF_AFTER   = 120;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int WATCHDOG_CYCLES  = 12000;
   localparam int DIRECTED_ROWS    = 32;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor;
      logic [15:0]         read_data;
      logic                scrolled;
   } console_result_type;

   typedef struct {
      logic [1:0]         func_code;
      logic [7:0]         char_code;
      logic [7:0]         attribute;
      logic [INDEX_W-1:0] cell_index;
      int                 count;
      bit                 given;
      console_result_type result;
   } stimulus_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_func = FUNC_PUT;
   logic [7:0]          req_char_code = 8'h00;
   logic [7:0]          req_attribute = 8'h00;
   logic [INDEX_W-1:0]  req_cell_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CURSOR_W-1:0] rsp_cursor_position;
   logic [15:0]         rsp_read_data;
   logic                rsp_scrolled;
   logic                csr_write_enable = 1'b0;
   logic [7:0]          csr_write_data = 8'h00;

   bit                 row_given = 1'b0;
   console_result_type row_result = '0;

   logic [15:0]     screen_model [CELL_COUNT];
   int              cursor_row_model = 0;
   int              cursor_col_model = 0;
   logic [7:0]      blank_attr_model = BLANK_ATTR_RESET;

   console_result_type expected_results [$];
   int                 mismatch_count = 0;
   int                 results_seen = 0;
   int                 quiet_cycles = 0;

   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{FUNC_READ,    8'h00, 8'h00, 11'd0,    1, 1'b1, '{11'd0,    16'h0F20, 1'b0}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd1999, 1, 1'b1, '{11'd0,    16'h0F20, 1'b0}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd2000, 1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd2047, 1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_NONE,    8'hFF, 8'hFF, 11'd2047, 1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h41, 8'h00, 11'd0,    1, 1'b1, '{11'd1,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h7E, 8'hFF, 11'd2047, 1, 1'b1, '{11'd2,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h20, 8'h5A, 11'd0,    1, 1'b1, '{11'd3,    16'h0000, 1'b0}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd1,    1, 1'b1, '{11'd3,    16'hFF7E, 1'b0}},
      '{FUNC_PUT,     CH_BS, 8'h00, 11'd0,    1, 1'b1, '{11'd2,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h7F, 8'h11, 11'd0,    1, 1'b1, '{11'd2,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'hFF, 8'h22, 11'd0,    1, 1'b1, '{11'd2,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h00, 8'h33, 11'd0,    1, 1'b1, '{11'd2,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h1F, 8'h44, 11'd0,    1, 1'b1, '{11'd2,    16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_TAB, 8'h00, 11'd0,   1, 1'b1, '{11'd8,    16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_CR, 8'h00, 11'd0,    1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_BS, 8'h00, 11'd0,    1, 1'b1, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_LF, 8'h00, 11'd0,    1, 1'b1, '{11'd80,   16'h0000, 1'b0}},
      '{FUNC_RECOLOR, 8'h00, 8'hA5, 11'd0,    1, 1'b1, '{11'd80,   16'h0000, 1'b0}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd0,    1, 1'b1, '{11'd80,   16'hA541, 1'b0}},
      '{FUNC_PUT,     CH_TAB, 8'h00, 11'd0,   9, 1'b0, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_TAB, 8'h00, 11'd0,   1, 1'b1, '{11'd160,  16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_TAB, 8'h00, 11'd0,   9, 1'b0, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h7A, 8'h3C, 11'd0,    7, 1'b0, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h71, 8'hC3, 11'd0,    1, 1'b1, '{11'd240,  16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_LF, 8'h00, 11'd0,   21, 1'b0, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     CH_LF, 8'h00, 11'd0,    1, 1'b1, '{11'd1920, 16'h0000, 1'b1}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd1999, 1, 1'b1, '{11'd1920, 16'h0F20, 1'b0}},
      '{FUNC_PUT,     CH_TAB, 8'h00, 11'd0,   9, 1'b0, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h77, 8'h81, 11'd0,    7, 1'b0, '{11'd0,    16'h0000, 1'b0}},
      '{FUNC_PUT,     8'h77, 8'h81, 11'd0,    1, 1'b1, '{11'd1920, 16'h0000, 1'b1}},
      '{FUNC_READ,    8'h00, 8'h00, 11'd1919, 1, 1'b1, '{11'd1920, 16'h8177, 1'b0}}
   };

   text_console_char_engine_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_attribute       (req_attribute),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_data       (rsp_read_data),
      .rsp_scrolled        (rsp_scrolled),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int pause_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic console_result_type console_step(logic [1:0] func_code,
                                                       logic [7:0] char_code,
                                                       logic [7:0] attribute,
                                                       logic [INDEX_W-1:0] cell_index);
      console_result_type res;
      int                 idx;
      res = '0;
      case (func_code)
         FUNC_PUT: begin
            if (char_code == CH_BS) begin
               if (cursor_col_model != 0) cursor_col_model--;
            end else if (char_code == CH_TAB) begin
               cursor_col_model = (cursor_col_model + TAB_STEP) & ~(TAB_STEP - 1);
            end else if (char_code == CH_CR) begin
               cursor_col_model = 0;
            end else if (char_code == CH_LF) begin
               cursor_col_model = 0;
               cursor_row_model++;
            end else if (char_code >= CH_SPACE && char_code <= CH_TILDE) begin
               idx = cursor_row_model * COLUMNS + cursor_col_model;
               if (idx < CELL_COUNT) screen_model[idx] = {attribute, char_code};
               cursor_col_model++;
            end
            if (cursor_col_model >= COLUMNS) begin
               cursor_col_model = 0;
               cursor_row_model++;
            end
            if (cursor_row_model >= ROWS) begin
               for (idx = 0; idx < CELL_COUNT - COLUMNS; idx++)
                  screen_model[idx] = screen_model[idx + COLUMNS];
               for (idx = CELL_COUNT - COLUMNS; idx < CELL_COUNT; idx++)
                  screen_model[idx] = {blank_attr_model, CH_SPACE};
               cursor_row_model = ROWS - 1;
               res.scrolled = 1'b1;
            end
         end
         FUNC_RECOLOR: begin
            for (idx = 0; idx < CELL_COUNT; idx++) screen_model[idx][15:8] = attribute;
         end
         FUNC_READ: begin
            if (cell_index < CELL_COUNT) res.read_data = screen_model[cell_index];
         end
         default: ;
      endcase
      res.cursor = CURSOR_W'(cursor_row_model * COLUMNS + cursor_col_model);
      return res;
   endfunction

   task automatic send_item(input logic [1:0] func_code, input logic [7:0] char_code,
                            input logic [7:0] attribute, input logic [INDEX_W-1:0] cell_index,
                            input bit given, input console_result_type result);
      int gap;
      gap = pause_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func_code;
      req_char_code  <= char_code;
      req_attribute  <= attribute;
      req_cell_index <= cell_index;
      row_given      <= given;
      row_result     <= result;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : scoreboard
      console_result_type want;
      console_result_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_cursor_position, rsp_read_data, rsp_scrolled};
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing pending: cursor %0d data %h scrolled %b",
                        $time, got.cursor, got.read_data, got.scrolled);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.cursor !== want.cursor) begin
                  $display("%0t: cursor_position expected %0d got %0d",
                           $time, want.cursor, got.cursor);
                  mismatch_count++;
               end
               if (got.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h got %h",
                           $time, want.read_data, got.read_data);
                  mismatch_count++;
               end
               if (got.scrolled !== want.scrolled) begin
                  $display("%0t: scrolled expected %b got %b",
                           $time, want.scrolled, got.scrolled);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = console_step(req_func, req_char_code, req_attribute, req_cell_index);
            expected_results.push_back(row_given ? row_result : want);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   initial begin : receiver
      int  gap;
      bit  held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = pause_length();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (!held && results_seen >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [7:0]         blank_settings [4];
      logic [1:0]         func_code;
      logic [7:0]         char_code;
      logic [7:0]         attribute;
      logic [INDEX_W-1:0] cell_index;
      int                 pick;
      int                 kind;
      for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {BLANK_ATTR_RESET, CH_SPACE};
      blank_settings = '{8'h00, 8'hFF, 8'h00, 8'h00};
      blank_settings[2] = 8'($urandom_range(1, 254));
      blank_settings[3] = 8'($urandom_range(0, 255));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         repeat (directed_rows[r].count)
            send_item(directed_rows[r].func_code, directed_rows[r].char_code,
                      directed_rows[r].attribute, directed_rows[r].cell_index,
                      directed_rows[r].given, directed_rows[r].result);
      end

      foreach (blank_settings[p]) begin
         wait_until_drained();
         csr_write_data   <= blank_settings[p];
         csr_write_enable <= 1'b1;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         blank_attr_model = blank_settings[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick       = $urandom_range(0, 99);
            char_code  = 8'($urandom_range(0, 255));
            attribute  = 8'($urandom_range(0, 255));
            cell_index = INDEX_W'($urandom_range(0, 2047));
            if (pick < 70) begin
               func_code = FUNC_PUT;
               kind = $urandom_range(0, 99);
               if (kind < 55) char_code = 8'($urandom_range(CH_SPACE, CH_TILDE));
               else if (kind < 70) char_code = CH_LF;
               else if (kind < 75) char_code = CH_CR;
               else if (kind < 82) char_code = CH_TAB;
               else if (kind < 88) char_code = CH_BS;
            end else if (pick < 73) begin
               func_code = FUNC_RECOLOR;
            end else if (pick < 96) begin
               func_code = FUNC_READ;
               if ($urandom_range(0, 3) != 0)
                  cell_index = INDEX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS,
                                                       CELL_COUNT - 1));
            end else begin
               func_code = FUNC_NONE;
            end
            send_item(func_code, char_code, attribute, cell_index, 1'b0, '0);
         end
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

/* text_console_char_engine_core.f */
+incdir+src
src/tcce_pkg.sv
src/text_console_char_engine_core.sv
src/tcce_checker.sv
dv/tb.sv
